/* hdl/quad_mesh_vertex_normal_assert.svh */
// Assertion macros for the quad mesh vertex normal block.
// Users supply clk and rst in scope; no other dependencies.
`ifndef QUAD_MESH_VERTEX_NORMAL_ASSERT_SVH
`define QUAD_MESH_VERTEX_NORMAL_ASSERT_SVH

// Same-cycle implication.
`define QMVN_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qmvn: assertion failed");

// Next-cycle implication.
`define QMVN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qmvn: assertion failed");

`endif

/* hdl/qmvn_pkg.sv */
// Shared constants and codes for the quad mesh vertex normal block.
// No dependencies.
`timescale 1ns / 1ps
package qmvn_pkg;
  localparam int NODES    = 1024;
  localparam int NODE_W   = $clog2(NODES);
  localparam int IDX_W    = 10;
  localparam int CORNERS  = 4;
  localparam int DIMS     = 3;
  localparam int COORD_W  = 24;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int ACC_W    = 20;
  localparam int NORM_W   = 16;
  localparam int MAG_W    = 51;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int DIV_W    = 48;
  localparam int QUO_BITS = 17;
  localparam int FRAC_W   = NORM_W - 1;
  localparam int TOP_BIT  = 30;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_ELEM  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;
endpackage

/* hdl/qmvn_req_if.sv */
// Request channel of the quad mesh vertex normal block.
// Depends on qmvn_pkg.
`timescale 1ns / 1ps
interface qmvn_req_if import qmvn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [IDX_W-1:0]          node_a;
  logic [IDX_W-1:0]          node_b;
  logic [IDX_W-1:0]          node_c;
  logic [IDX_W-1:0]          node_d;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  modport source(output valid, func, node_a, node_b, node_c, node_d,
                 coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, func, node_a, node_b, node_c, node_d,
               coord_x, coord_y, coord_z, output ready);
endinterface

/* hdl/qmvn_rsp_if.sv */
// Response channel of the quad mesh vertex normal block.
// Depends on qmvn_pkg.
`timescale 1ns / 1ps
interface qmvn_rsp_if import qmvn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic [1:0]               status;
  modport source(output valid, norm_x, norm_y, norm_z, status, input ready);
  modport sink(input valid, norm_x, norm_y, norm_z, status, output ready);
endinterface

/* hdl/qmvn_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module qmvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/quad_mesh_vertex_normal.sv */
// Quad mesh vertex normal averaging: coordinate store, accumulators, shared datapath.
// Depends on qmvn_pkg, qmvn_req_if, qmvn_rsp_if, qmvn_ram and the assertion header.
//
//   channel | dir | payload
//   req     | in  | func, node_a..node_d, coord_x/y/z
//   rsp     | out | norm_x/y/z, status
//
// Read and element run time grows with the normalizing shifts, and an element repeats its work per corner;
// a zero sum skips the shifter, square root and divider.
// One 32x32 multiplier, a one-bit-a-step shifter, a 32-step square root and a divider that
// serves one component at a time are reused under the sequencer.
// After reset a clearing pass over all NODES accumulator entries runs before the first transaction.
// A waiting response holds the output register; the next one holds in place and stalls req.
`timescale 1ns / 1ps
`include "quad_mesh_vertex_normal_assert.svh"
module quad_mesh_vertex_normal import qmvn_pkg::*; (
  input logic      clk,
  input logic      rst,
  qmvn_req_if.sink   req,
  qmvn_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_CRD, S_CROSS, S_CHK, S_SHIFT, S_SQ, S_SQRT,
    S_DIV, S_ACC, S_RESP
  } state_t;

  state_t                     state;
  logic [5:0]                 step;
  logic [1:0]                 func;
  logic [NODE_W-1:0]          nd [CORNERS];
  logic [1:0]                 corner;
  logic [NODE_W-1:0]          clr_addr;
  logic                       clr_resp;
  logic signed [COORD_W-1:0]  pc [DIMS];
  logic signed [COORD_W-1:0]  pnc [DIMS];
  logic signed [COORD_W-1:0]  ppc [DIMS];
  logic signed [EDGE_W-1:0]   e1 [DIMS];
  logic signed [EDGE_W-1:0]   e2 [DIMS];
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   part;
  logic [MAG_W-1:0]           mag [DIMS];
  logic                       neg [DIMS];
  logic [SUM_W-1:0]           ssum;
  logic [SUM_W-1:0]           sq_s;
  logic [SUM_W-1:0]           sq_r;
  logic [SUM_W-1:0]           sq_bit;
  logic [DIV_W-1:0]           div_rem;
  logic [DIV_W-1:0]           div_dsr;
  logic [QUO_BITS-1:0]        div_q;
  logic [1:0]                 div_idx;
  logic signed [NORM_W-1:0]   unit [DIMS];
  logic                       zero_flag;
  logic                       sat_flag;
  logic [1:0]                 res_status;

  logic                        crd_we;
  logic [NODE_W-1:0]           crd_raddr;
  logic [DIMS*COORD_W-1:0]     crd_rdata;
  logic                        acc_we;
  logic [NODE_W-1:0]           acc_waddr;
  logic [DIMS*ACC_W-1:0]       acc_wdata;
  logic [DIMS*ACC_W-1:0]       acc_rdata;
  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]    cdiff;
  logic [1:0]                  cidx;
  logic [MAG_W-1:0]            mx;
  logic signed [ACC_W:0]       asum [DIMS];
  logic signed [ACC_W:0]       aext [DIMS];
  logic [ACC_W-1:0]            anew [DIMS];
  logic                        sat_now;
  logic                        div_ge;
  logic [QUO_BITS-1:0]         div_cap;
  logic signed [NORM_W-1:0]    div_unit;
  logic                        all_zero;

  localparam logic [MAG_W-1:0]    MAG_HI  = MAG_W'(1) << TOP_BIT;
  localparam logic [MAG_W-1:0]    MAG_LO  = MAG_W'(1) << (TOP_BIT - 1);
  localparam logic [QUO_BITS-1:0] NEG_CAP = QUO_BITS'(1) << FRAC_W;
  localparam logic [QUO_BITS-1:0] POS_CAP = NEG_CAP - QUO_BITS'(1);

  assign req.ready = (state == S_IDLE);
  assign crd_we    = req.valid && req.ready && (req.func == FUNC_LOAD);

  qmvn_ram #(.WIDTH(DIMS * COORD_W), .DEPTH(NODES)) u_crd_ram (
    .clk   (clk),
    .we    (crd_we),
    .waddr (req.node_a[NODE_W-1:0]),
    .wdata ({req.coord_x, req.coord_y, req.coord_z}),
    .raddr (crd_raddr),
    .rdata (crd_rdata)
  );

  qmvn_ram #(.WIDTH(DIMS * ACC_W), .DEPTH(NODES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (nd[corner]),
    .rdata (acc_rdata)
  );

  always_comb begin
    case (step)
      6'd1:    crd_raddr = nd[corner + 2'd1];
      6'd2:    crd_raddr = nd[corner - 2'd1];
      default: crd_raddr = nd[corner];
    endcase

    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      case (step)
        6'd0: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[2]); end
        6'd1: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[1]); end
        6'd2: begin mul_a = MUL_W'(e1[2]); mul_b = MUL_W'(e2[0]); end
        6'd3: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[2]); end
        6'd4: begin mul_a = MUL_W'(e1[0]); mul_b = MUL_W'(e2[1]); end
        6'd5: begin mul_a = MUL_W'(e1[1]); mul_b = MUL_W'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == S_SQ && step < 6'(DIMS)) begin
      mul_a = {2'b00, mag[step[1:0]][TOP_BIT-1:0]};
      mul_b = {2'b00, mag[step[1:0]][TOP_BIT-1:0]};
    end

    cdiff = part - prod;
    cidx  = 2'((step - 6'd1) >> 1);

    mx = mag[0];
    for (int i = 1; i < DIMS; i++) begin
      if (mag[i] > mx) mx = mag[i];
    end
    all_zero = (mx == '0);

    sat_now = 1'b0;
    for (int i = 0; i < DIMS; i++) begin
      aext[i] = (ACC_W + 1)'($signed(acc_rdata[(DIMS-1-i)*ACC_W +: ACC_W]));
      asum[i] = aext[i] + (ACC_W + 1)'(unit[i]);
      if (asum[i][ACC_W] != asum[i][ACC_W-1]) begin
        anew[i] = {asum[i][ACC_W], {(ACC_W - 1){~asum[i][ACC_W]}}};
        sat_now = 1'b1;
      end else begin
        anew[i] = asum[i][ACC_W-1:0];
      end
    end

    acc_we    = 1'b0;
    acc_waddr = nd[corner];
    acc_wdata = {anew[0], anew[1], anew[2]};
    if (state == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr;
      acc_wdata = '0;
    end else if (state == S_ACC && step == 6'd1) begin
      acc_we = 1'b1;
    end

    div_ge = (div_rem >= div_dsr);
    if (neg[div_idx]) begin
      div_cap  = (div_q > NEG_CAP) ? NEG_CAP : div_q;
      div_unit = NORM_W'(QUO_BITS'(0) - div_cap);
    end else begin
      div_cap  = (div_q > POS_CAP) ? POS_CAP : div_q;
      div_unit = NORM_W'(div_cap);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_resp   <= 1'b0;
      step       <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_RESP) rsp.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == '1) begin
            res_status <= STATUS_OK;
            state      <= clr_resp ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            func      <= req.func;
            nd[0]     <= req.node_a[NODE_W-1:0];
            nd[1]     <= req.node_b[NODE_W-1:0];
            nd[2]     <= req.node_c[NODE_W-1:0];
            nd[3]     <= req.node_d[NODE_W-1:0];
            corner    <= '0;
            step      <= '0;
            zero_flag <= 1'b0;
            sat_flag  <= 1'b0;
            case (req.func)
              FUNC_LOAD: begin
                res_status <= STATUS_OK;
                state      <= S_RESP;
              end
              FUNC_ELEM:  state <= S_CRD;
              FUNC_READ:  state <= S_ARD;
              FUNC_CLEAR: begin
                clr_addr <= '0;
                clr_resp <= 1'b1;
                state    <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ARD: begin
          step <= step + 6'd1;
          if (step == 6'd1) begin
            for (int i = 0; i < DIMS; i++) begin
              neg[i] <= aext[i] < 0;
              mag[i] <= MAG_W'(aext[i] < 0 ? -aext[i] : aext[i]);
            end
            state <= S_CHK;
          end
        end
        S_CRD: begin
          for (int i = 0; i < DIMS; i++) begin
            case (step)
              6'd1: pc[i]  <= crd_rdata[(DIMS-1-i)*COORD_W +: COORD_W];
              6'd2: pnc[i] <= crd_rdata[(DIMS-1-i)*COORD_W +: COORD_W];
              6'd3: ppc[i] <= crd_rdata[(DIMS-1-i)*COORD_W +: COORD_W];
              6'd4: begin
                e1[i] <= EDGE_W'(pnc[i]) - EDGE_W'(pc[i]);
                e2[i] <= EDGE_W'(ppc[i]) - EDGE_W'(pc[i]);
              end
              default: ;
            endcase
          end
          if (step == 6'd4) begin
            step  <= '0;
            state <= S_CROSS;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_CROSS: begin
          step <= step + 6'd1;
          if (step != 6'd0) begin
            if (!step[0]) begin
              neg[cidx] <= cdiff < 0;
              mag[cidx] <= MAG_W'(cdiff < 0 ? -cdiff : cdiff);
            end else begin
              part <= prod;
            end
          end
          if (step == 6'd6) state <= S_CHK;
        end
        S_CHK: begin
          step <= '0;
          if (!all_zero) begin
            state <= S_SHIFT;
          end else if (func == FUNC_READ) begin
            res_status <= STATUS_ZERO;
            state      <= S_RESP;
          end else begin
            zero_flag <= 1'b1;
            corner    <= corner + 2'd1;
            if (corner == 2'(CORNERS - 1)) begin
              res_status <= STATUS_ZERO;
              state      <= S_RESP;
            end else begin
              state <= S_CRD;
            end
          end
        end
        S_SHIFT: begin
          if (mx >= MAG_HI) begin
            for (int i = 0; i < DIMS; i++) mag[i] <= mag[i] >> 1;
          end else if (mx < MAG_LO) begin
            for (int i = 0; i < DIMS; i++) mag[i] <= mag[i] << 1;
          end else begin
            ssum  <= '0;
            step  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          step <= step + 6'd1;
          if (step != 6'd0) ssum <= ssum + SUM_W'(prod);
          if (step == 6'(DIMS)) begin
            sq_s   <= ssum + SUM_W'(prod);
            sq_r   <= '0;
            sq_bit <= SUM_W'(1) << (SUM_W - 2);
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_s >= sq_r + sq_bit) begin
            sq_s <= sq_s - (sq_r + sq_bit);
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            div_idx <= '0;
            step    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == 6'd0) begin
            step    <= step + 6'd1;
            div_rem <= DIV_W'({mag[div_idx][TOP_BIT-1:0], {FRAC_W{1'b0}}})
                       + DIV_W'(sq_r[ROOT_W-1:1]);
            div_dsr <= DIV_W'(sq_r[ROOT_W-1:0]) << (QUO_BITS - 1);
            div_q   <= '0;
          end else if (step <= 6'(QUO_BITS)) begin
            step <= step + 6'd1;
            if (div_ge) begin
              div_rem <= div_rem - div_dsr;
              div_q   <= {div_q[QUO_BITS-2:0], 1'b1};
            end else begin
              div_q   <= {div_q[QUO_BITS-2:0], 1'b0};
            end
            div_dsr <= div_dsr >> 1;
          end else begin
            unit[div_idx] <= div_unit;
            step          <= '0;
            div_idx       <= div_idx + 2'd1;
            if (div_idx == 2'(DIMS - 1)) begin
              if (func == FUNC_READ) begin
                res_status <= STATUS_OK;
                state      <= S_RESP;
              end else begin
                state <= S_ACC;
              end
            end
          end
        end
        S_ACC: begin
          if (step == 6'd1) begin
            step     <= '0;
            sat_flag <= sat_flag | sat_now;
            corner   <= corner + 2'd1;
            if (corner == 2'(CORNERS - 1)) begin
              res_status <= zero_flag ? STATUS_ZERO :
                            ((sat_flag | sat_now) ? STATUS_SAT : STATUS_OK);
              state      <= S_RESP;
            end else begin
              state <= S_CRD;
            end
          end else begin
            step <= step + 6'd1;
          end
        end
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid  <= 1'b1;
            rsp.status <= res_status;
            clr_resp   <= 1'b0;
            if (func == FUNC_READ && res_status == STATUS_OK) begin
              rsp.norm_x <= unit[0];
              rsp.norm_y <= unit[1];
              rsp.norm_z <= unit[2];
            end else begin
              rsp.norm_x <= '0;
              rsp.norm_y <= '0;
              rsp.norm_z <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `QMVN_ASSERT_IMPL(a_div_len, state == S_DIV, sq_r != '0)
  `QMVN_ASSERT_IMPL(a_sq_range, state == S_SQ, mx >= MAG_LO && mx < MAG_HI)
  `QMVN_ASSERT_IMPL(a_acc_we, acc_we, state == S_CLEAR || state == S_ACC)
  `QMVN_ASSERT_IMPL(a_rsp_zero, rsp.valid && rsp.status != STATUS_OK,
                    rsp.norm_x == '0 && rsp.norm_y == '0 && rsp.norm_z == '0)
  `QMVN_ASSERT_NEXT(a_busy, req.valid && req.ready, !req.ready)
endmodule

/* bench/testbench.sv */
// Self-checking bench for quad_mesh_vertex_normal: directed table, then random meshes.
// Depends on qmvn_pkg, qmvn_req_if, qmvn_rsp_if and the block under test.
`timescale 1ns / 1ps
module testbench;
  import qmvn_pkg::*;

  typedef struct {
    logic [1:0]         func;
    logic [IDX_W-1:0]   na, nb, nc, nd;
    logic signed [23:0] cx, cy, cz;
  } req_t;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz;
    logic [1:0]         st;
  } rsp_t;

  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t e;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  qmvn_req_if req();
  qmvn_rsp_if rsp();

  quad_mesh_vertex_normal dut(.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  longint coords[NODES][3];
  bit     loaded[NODES];
  int     accum[NODES][3];
  rsp_t   pending[$];
  int     errors = 0;
  longint cycles = 0;
  bit     hold_rsp = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd30000000) begin
      $display("quad_mesh_vertex_normal regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input longint v[3], output int u[3]);
    longint unsigned mag[3], m, s, len, q;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 32768 + len / 2) / len;
      if (v[i] < 0) begin
        if (q > 32768) q = 32768;
        u[i] = -int'(q);
      end else begin
        if (q > 32767) q = 32767;
        u[i] = int'(q);
      end
    end
    return 1;
  endfunction

  function automatic rsp_t mesh_normal(req_t r);
    rsp_t o;
    int n[4];
    int u[3];
    longint e1[3], e2[3], c[3], v[3];
    bit zero, sat;
    int a;
    o = '{0, 0, 0, STATUS_OK};
    zero = 0;
    sat = 0;
    case (r.func)
      FUNC_LOAD: begin
        coords[r.na] = '{longint'(r.cx), longint'(r.cy), longint'(r.cz)};
        loaded[r.na] = 1;
      end
      FUNC_ELEM: begin
        n = '{int'(r.na), int'(r.nb), int'(r.nc), int'(r.nd)};
        for (int j = 0; j < 4; j++) begin
          for (int i = 0; i < 3; i++) begin
            e1[i] = coords[n[(j + 1) % 4]][i] - coords[n[j]][i];
            e2[i] = coords[n[(j + 3) % 4]][i] - coords[n[j]][i];
          end
          c[0] = e1[1] * e2[2] - e1[2] * e2[1];
          c[1] = e1[2] * e2[0] - e1[0] * e2[2];
          c[2] = e1[0] * e2[1] - e1[1] * e2[0];
          if (!unit_vec(c, u)) begin
            zero = 1;
            continue;
          end
          for (int i = 0; i < 3; i++) begin
            a = accum[n[j]][i] + u[i];
            if (a > 524287) begin
              a = 524287;
              sat = 1;
            end else if (a < -524288) begin
              a = -524288;
              sat = 1;
            end
            accum[n[j]][i] = a;
          end
        end
        o.st = zero ? STATUS_ZERO : (sat ? STATUS_SAT : STATUS_OK);
      end
      FUNC_READ: begin
        for (int i = 0; i < 3; i++) v[i] = longint'(accum[r.na][i]);
        if (!unit_vec(v, u)) o.st = STATUS_ZERO;
        o.nx = 16'(u[0]);
        o.ny = 16'(u[1]);
        o.nz = 16'(u[2]);
      end
      default: begin
        for (int k = 0; k < NODES; k++) accum[k] = '{0, 0, 0};
      end
    endcase
    return o;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic signed [23:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return -24'sh800000;
      2: return 24'(int'($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send(req_t r, bit fixed, rsp_t e);
    rsp_t p;
    int g;
    p = mesh_normal(r);
    if (fixed && p != e) begin
      $display("%0t table row disagrees: expected %p got %p", $time, e, p);
      errors++;
    end
    pending.push_back(p);
    req.valid <= 1;
    req.func <= r.func;
    req.node_a <= r.na;
    req.node_b <= r.nb;
    req.node_c <= r.nc;
    req.node_d <= r.nd;
    req.coord_x <= r.cx;
    req.coord_y <= r.cy;
    req.coord_z <= r.cz;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic req_t mk(logic [1:0] f, int a, int b, int c, int d,
                              longint x, longint y, longint z);
    req_t r;
    r = '{f, IDX_W'(a), IDX_W'(b), IDX_W'(c), IDX_W'(d), 24'(x), 24'(y), 24'(z)};
    return r;
  endfunction

  function automatic int pick_loaded();
    int k;
    do k = $urandom_range(0, 15) + 16 * $urandom_range(0, 63);
    while (!loaded[k]);
    return k;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result %p", $time, rsp.status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (rsp.norm_x !== e.nx || rsp.norm_y !== e.ny || rsp.norm_z !== e.nz ||
            rsp.status !== e.st)
          $display("%0t mismatch: expected %0d %0d %0d st %0d, actual %0d %0d %0d st %0d",
                   $time, e.nx, e.ny, e.nz, e.st,
                   rsp.norm_x, rsp.norm_y, rsp.norm_z, rsp.status);
        if (rsp.norm_x !== e.nx || rsp.norm_y !== e.ny || rsp.norm_z !== e.nz ||
            rsp.status !== e.st)
          errors++;
      end
    end
  end

  initial begin
    int g;
    rsp.ready = 0;
    @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 0;
        repeat (3000) @(negedge clk);
        hold_rsp = 0;
      end
      rsp.ready <= 1;
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        rsp.ready <= 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  initial begin
    row_t tbl[$];
    rsp_t z0;
    rsp_t zf;
    req_t r;
    int a, b, c, d, base, len;
    z0 = '{0, 0, 0, STATUS_OK};
    zf = '{0, 0, 0, STATUS_ZERO};
    req.valid = 0;
    req.func = FUNC_LOAD;
    {req.node_a, req.node_b, req.node_c, req.node_d} = '0;
    {req.coord_x, req.coord_y, req.coord_z} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    tbl.push_back('{mk(FUNC_READ, 5, 0, 0, 0, 0, 0, 0), 1, zf});
    tbl.push_back('{mk(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0), 1, z0});
    tbl.push_back('{mk(FUNC_LOAD, 1, 0, 0, 0, 1000, 0, 0), 1, z0});
    tbl.push_back('{mk(FUNC_LOAD, 2, 0, 0, 0, 1000, 1000, 0), 1, z0});
    tbl.push_back('{mk(FUNC_LOAD, 3, 0, 0, 0, 0, 1000, 0), 1, z0});
    tbl.push_back('{mk(FUNC_ELEM, 0, 1, 2, 3, 0, 0, 0), 1, z0});
    tbl.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 32767, STATUS_OK}});
    tbl.push_back('{mk(FUNC_ELEM, 0, 0, 2, 3, 0, 0, 0), 1, '{0, 0, 0, STATUS_ZERO}});
    tbl.push_back('{mk(FUNC_ELEM, 3, 2, 1, 0, 0, 0, 0), 0, z0});
    tbl.push_back('{mk(FUNC_READ, 1, 0, 0, 0, 0, 0, 0), 0, z0});
    tbl.push_back('{mk(FUNC_LOAD, 1023, 0, 0, 0, 8388607, -8388608, 8388607), 1, z0});
    tbl.push_back('{mk(FUNC_LOAD, 1022, 0, 0, 0, -8388608, 8388607, -8388608), 1, z0});
    tbl.push_back('{mk(FUNC_LOAD, 1021, 0, 0, 0, -8388608, -8388608, 8388607), 1, z0});
    tbl.push_back('{mk(FUNC_ELEM, 1023, 1022, 1021, 0, 0, 0, 0), 0, z0});
    tbl.push_back('{mk(FUNC_READ, 1023, 0, 0, 0, 0, 0, 0), 0, z0});
    tbl.push_back('{mk(FUNC_READ, 1021, 0, 0, 0, 0, 0, 0), 0, z0});
    tbl.push_back('{mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, z0});
    tbl.push_back('{mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, zf});
    foreach (tbl[i]) send(tbl[i].r, tbl[i].fixed, tbl[i].e);

    // Saturation: drive one node past the accumulator range.
    for (int k = 0; k < 17; k++) send(mk(FUNC_ELEM, 0, 1, 2, 3, 0, 0, 0), 0, z0);
    send(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 0, z0);
    drain();

    hold_rsp = 1;
    for (int n = 0; n < 1650; n++) begin
      if (n == 800) drain();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          r = mk(FUNC_LOAD, $urandom_range(0, 1023), 0, 0, 0, 0, 0, 0);
          r.nb = IDX_W'($urandom);
          r.nc = IDX_W'($urandom);
          r.nd = IDX_W'($urandom);
          r.cx = rnd_coord();
          r.cy = rnd_coord();
          r.cz = rnd_coord();
        end
        5, 6, 7, 8, 9, 10, 11, 12: begin
          if ($urandom_range(0, 3) == 0) begin
            a = pick_loaded();
            b = pick_loaded();
            c = pick_loaded();
            d = pick_loaded();
          end else begin
            base = 4 * $urandom_range(0, 255);
            a = base; b = base + 1; c = base + 2; d = base + 3;
            if (!(loaded[a] && loaded[b] && loaded[c] && loaded[d])) begin
              a = pick_loaded(); b = pick_loaded(); c = pick_loaded(); d = pick_loaded();
            end
          end
          r = mk(FUNC_ELEM, a, b, c, d, 0, 0, 0);
          r.cx = 24'($urandom);
          r.cy = 24'($urandom);
          r.cz = 24'($urandom);
        end
        13, 14, 15, 16, 17, 18: begin
          r = mk(FUNC_READ, $urandom_range(0, 1023), $urandom, $urandom, $urandom, 0, 0, 0);
          r.cx = 24'($urandom);
        end
        default: begin
          if ($urandom_range(0, 3) == 0)
            r = mk(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
          else
            r = mk(FUNC_READ, pick_loaded(), 0, 0, 0, 0, 0, 0);
        end
      endcase
      send(r, 0, z0);
    end
    req.valid <= 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (errors == 0)
      $display("quad_mesh_vertex_normal regression: pass");
    else
      $display("quad_mesh_vertex_normal regression: fail");
    $finish;
  end

  initial begin
    for (int k = 0; k < NODES; k++) begin
      coords[k] = '{0, 0, 0};
      accum[k] = '{0, 0, 0};
      loaded[k] = 0;
    end
  end
endmodule
